// File: sv/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define VIFX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define VIFX_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: sv/vifx_pkg.sv
// -----------------------------------------------------------------------------
// vifx_pkg
// Shared types and codes of the unpack vertex extractor.
// -----------------------------------------------------------------------------
package vifx_pkg;

   localparam int OFFSET_BITS_DEF = 20;

   // Configuration port
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 21;
   localparam int SIZE_W           = 21;
   localparam int VTX_W            = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VERTICES = 2'd1;
   localparam logic [SIZE_W-1:0]    SECTOR_SIZE_RST  = 21'd1;
   localparam logic [VTX_W-1:0]     MAX_VERTICES_RST = 16'hFFFF;

   // Record kinds
   localparam logic [1:0] KIND_POS = 2'd0;
   localparam logic [1:0] KIND_UV  = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   // Command decode
   localparam logic [7:0] CMD_STCYCL  = 8'h01;
   localparam logic [7:0] UNPACK_MASK = 8'h60;
   localparam logic [1:0] VN_V2       = 2'd1;
   localparam logic [1:0] VN_V4       = 2'd3;
   localparam logic [1:0] VL_32       = 2'd0;
   localparam logic [1:0] VL_16       = 2'd1;
   localparam logic [1:0] VL_8        = 2'd2;
   localparam logic [1:0] VL_5        = 2'd3;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef struct packed {
      logic [1:0]         record_kind;
      logic [15:0]        record_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [15:0]        vertex_flag;
      logic signed [15:0] tex_u;
      logic signed [15:0] tex_v;
      logic [15:0]        total_vertices;
      logic               last;
   } record_type;

   // Results of one item: count is 0, 1 or 2, first always filled first.
   typedef struct packed {
      logic [1:0] count;
      record_type first;
      record_type second;
   } slots_type;

endpackage

// File: sv/vifx_parser.sv
// -----------------------------------------------------------------------------
// vifx_parser
// Per-byte header search, payload walk and record assembly of one sector.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module vifx_parser #(
   parameter int OFFSET_BITS = vifx_pkg::OFFSET_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [7:0]                    byte_value,
   input  logic [vifx_pkg::SIZE_W-1:0]   sector_size,
   input  logic [vifx_pkg::VTX_W-1:0]    max_vertices,
   output vifx_pkg::slots_type           slots
);

   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_SKIP   = 2'd1;
   localparam logic [1:0] MODE_POS    = 2'd2;
   localparam logic [1:0] MODE_UV     = 2'd3;

   localparam int CW = ((OFFSET_BITS + 1) > vifx_pkg::SIZE_W ?
                        (OFFSET_BITS + 1) : vifx_pkg::SIZE_W) + 1;

   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic [23:0]            window_ff, window_in;
   logic [2:0]             fill_ff, fill_in;
   logic [1:0]             mode_ff, mode_in;
   logic [11:0]            payload_ff, payload_in;
   logic [7:0]             elem_ff, elem_in;
   logic [2:0]             rbp_ff, rbp_in;
   logic [55:0]            asm_ff, asm_in;
   logic [15:0]            pos_cnt_ff, pos_cnt_in;
   logic [15:0]            uv_cnt_ff, uv_cnt_in;

   logic [CW-1:0] size_raw, size_lim, size_eff, offset_inc;
   logic          is_last, live;
   logic [7:0]    num;
   logic [1:0]    vt, dt;
   logic [2:0]    vt_inc;
   logic [4:0]    row_elem;
   logic [11:0]   prod, prod_up, unpack_bytes;
   logic          is_stcycl, is_unpack, is_v4_16, is_v2_16;
   logic [11:0]   payload_dec;
   logic [7:0]    elem_dec;
   logic [2:0]    need;

   vifx_pkg::record_type rec, end_rec;
   logic                 rec_valid;

   // Effective sector size, clamped to 1 .. 2^OFFSET_BITS
   assign size_raw   = CW'(sector_size);
   assign size_lim   = CW'(1) << OFFSET_BITS;
   assign offset_inc = CW'(byte_offset_ff) + CW'(1);

   always_comb begin
      priority if (size_raw == '0) begin
         size_eff = CW'(1);
      end else if (size_raw > size_lim) begin
         size_eff = size_lim;
      end else begin
         size_eff = size_raw;
      end
   end

   assign is_last = offset_inc >= size_eff;
   assign live    = !is_last;

   // Header decode: command is this byte, count is the byte before it
   assign num       = window_ff[7:0];
   assign vt        = byte_value[3:2];
   assign dt        = byte_value[1:0];
   assign vt_inc    = 3'(vt) + 3'd1;
   assign is_stcycl = byte_value == vifx_pkg::CMD_STCYCL;
   assign is_unpack = (byte_value & vifx_pkg::UNPACK_MASK) == vifx_pkg::UNPACK_MASK;
   assign is_v4_16  = (vt == vifx_pkg::VN_V4) && (dt == vifx_pkg::VL_16);
   assign is_v2_16  = (vt == vifx_pkg::VN_V2) && (dt == vifx_pkg::VL_16);

   always_comb begin
      unique case (dt)
         vifx_pkg::VL_32: row_elem = 5'(vt_inc) << 2;
         vifx_pkg::VL_16: row_elem = 5'(vt_inc) << 1;
         vifx_pkg::VL_8:  row_elem = 5'(vt_inc);
         vifx_pkg::VL_5:  row_elem = 5'd2;
         default:         row_elem = 5'd0;
      endcase
   end

   assign prod         = 12'(num) * 12'(row_elem);
   assign prod_up      = prod + 12'd3;
   assign unpack_bytes = {prod_up[11:2], 2'b00};

   assign payload_dec = (payload_ff == '0) ? 12'd0 : payload_ff - 12'd1;
   assign elem_dec    = (elem_ff == '0) ? 8'd0 : elem_ff - 8'd1;
   assign need        = (mode_ff == MODE_POS) ? 3'd7 : 3'd3;

   always_comb begin
      byte_offset_in = byte_offset_ff;
      window_in      = window_ff;
      fill_in        = fill_ff;
      mode_in        = mode_ff;
      payload_in     = payload_ff;
      elem_in        = elem_ff;
      rbp_in         = rbp_ff;
      asm_in         = asm_ff;
      pos_cnt_in     = pos_cnt_ff;
      uv_cnt_in      = uv_cnt_ff;
      rec_valid      = 1'b0;
      rec            = '0;
      end_rec        = '0;

      unique case (mode_ff)
         MODE_SEARCH: begin
            if (fill_ff < 3'd3) begin
               window_in = {window_ff[15:0], byte_value};
               fill_in   = fill_ff + 3'd1;
            end else if (live && is_stcycl) begin
               window_in = '0;
               fill_in   = '0;
            end else if (live && is_unpack) begin
               window_in  = '0;
               fill_in    = '0;
               payload_in = '0;
               elem_in    = '0;
               rbp_in     = '0;
               asm_in     = '0;
               if (is_v4_16 && num != '0) begin
                  mode_in = MODE_POS;
                  elem_in = num;
               end else if (is_v2_16 && num != '0) begin
                  mode_in = MODE_UV;
                  elem_in = num;
               end else if (unpack_bytes != '0) begin
                  mode_in    = MODE_SKIP;
                  payload_in = unpack_bytes;
               end
            end else begin
               window_in = {window_ff[15:0], byte_value};
            end
         end
         MODE_SKIP: begin
            payload_in = payload_dec;
            if (payload_dec == '0) begin
               mode_in   = MODE_SEARCH;
               window_in = '0;
               fill_in   = '0;
               elem_in   = '0;
               rbp_in    = '0;
               asm_in    = '0;
            end
         end
         MODE_POS, MODE_UV: begin
            if (rbp_ff < need) begin
               asm_in = asm_ff | (56'(byte_value) << {rbp_ff, 3'b000});
               rbp_in = rbp_ff + 3'd1;
            end else begin
               if (mode_ff == MODE_POS) begin
                  if (pos_cnt_ff < max_vertices) begin
                     rec_valid        = 1'b1;
                     rec.record_kind  = vifx_pkg::KIND_POS;
                     rec.record_index = pos_cnt_ff;
                     rec.pos_x        = asm_ff[15:0];
                     rec.pos_y        = asm_ff[31:16];
                     rec.pos_z        = asm_ff[47:32];
                     rec.vertex_flag  = {byte_value, asm_ff[55:48]};
                     pos_cnt_in       = pos_cnt_ff + 16'd1;
                  end
               end else begin
                  if (uv_cnt_ff < max_vertices) begin
                     rec_valid        = 1'b1;
                     rec.record_kind  = vifx_pkg::KIND_UV;
                     rec.record_index = uv_cnt_ff;
                     rec.tex_u        = asm_ff[15:0];
                     rec.tex_v        = {byte_value, asm_ff[23:16]};
                     uv_cnt_in        = uv_cnt_ff + 16'd1;
                  end
               end
               asm_in  = '0;
               rbp_in  = '0;
               elem_in = elem_dec;
               if (elem_dec == '0) begin
                  mode_in    = MODE_SEARCH;
                  window_in  = '0;
                  fill_in    = '0;
                  payload_in = '0;
               end
            end
         end
         default: begin
            mode_in = MODE_SEARCH;
         end
      endcase

      if (is_last) begin
         end_rec.record_kind    = vifx_pkg::KIND_END;
         end_rec.total_vertices = pos_cnt_in;
         end_rec.last           = 1'b1;
         // drop all per-sector state for the next sector
         byte_offset_in = '0;
         window_in      = '0;
         fill_in        = '0;
         mode_in        = MODE_SEARCH;
         payload_in     = '0;
         elem_in        = '0;
         rbp_in         = '0;
         asm_in         = '0;
         pos_cnt_in     = '0;
         uv_cnt_in      = '0;
      end else begin
         byte_offset_in = byte_offset_ff + OFFSET_BITS'(1);
      end
   end

   always_comb begin
      slots        = '0;
      slots.second = end_rec;
      priority if (rec_valid && is_last) begin
         slots.count  = 2'd2;
         slots.first  = rec;
      end else if (rec_valid) begin
         slots.count  = 2'd1;
         slots.first  = rec;
      end else if (is_last) begin
         slots.count  = 2'd1;
         slots.first  = end_rec;
      end else begin
         slots.count  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff <= '0;
         window_ff      <= '0;
         fill_ff        <= '0;
         mode_ff        <= MODE_SEARCH;
         payload_ff     <= '0;
         elem_ff        <= '0;
         rbp_ff         <= '0;
         asm_ff         <= '0;
         pos_cnt_ff     <= '0;
         uv_cnt_ff      <= '0;
      end else if (go) begin
         byte_offset_ff <= byte_offset_in;
         window_ff      <= window_in;
         fill_ff        <= fill_in;
         mode_ff        <= mode_in;
         payload_ff     <= payload_in;
         elem_ff        <= elem_in;
         rbp_ff         <= rbp_in;
         asm_ff         <= asm_in;
         pos_cnt_ff     <= pos_cnt_in;
         uv_cnt_ff      <= uv_cnt_in;
      end
   end

   `VIFX_ASSERT(a_end_clears, go && is_last |=> byte_offset_ff == '0 && pos_cnt_ff == '0, "sector state not cleared after end record")
   `VIFX_NEVER(a_fill_in_payload, mode_ff != MODE_SEARCH && fill_ff != '0, "header window filled outside search")

endmodule

// File: sv/vifx_rsp_fifo.sv
// -----------------------------------------------------------------------------
// vifx_rsp_fifo
// Result queue: takes up to two records per cycle, hands out one per cycle while rsp_stall is low.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module vifx_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  vifx_pkg::slots_type  push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vifx_pkg::record_type head
);

   vifx_pkg::record_type entry_ff [vifx_pkg::RSP_DEPTH];

   logic [vifx_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vifx_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vifx_pkg::RSP_PTR_W-1:0] wr_ptr_nxt;
   logic [vifx_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                           pop;

   assign rsp_valid  = count_ff != '0;
   assign pop        = rsp_valid && !rsp_stall;
   assign head       = entry_ff[rd_ptr_ff];
   // leave space for the two records one item may bring
   assign room       = count_ff <= vifx_pkg::RSP_CNT_W'(vifx_pkg::RSP_DEPTH - 2);
   assign wr_ptr_nxt = wr_ptr_ff + vifx_pkg::RSP_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + vifx_pkg::RSP_PTR_W'(push.count);
   assign rd_ptr_in  = rd_ptr_ff + vifx_pkg::RSP_PTR_W'(pop);
   assign count_in   = count_ff + vifx_pkg::RSP_CNT_W'(push.count)
                       - vifx_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_nxt] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `VIFX_NEVER(a_cnt_range, count_ff > vifx_pkg::RSP_CNT_W'(vifx_pkg::RSP_DEPTH), "result queue count out of range")
   `VIFX_NEVER(a_push_full, push.count != 2'd0 && !room, "records pushed without room")

endmodule

// File: sv/vif_unpack_vertex_extractor_unit.sv
// -----------------------------------------------------------------------------
// vif_unpack_vertex_extractor_unit
// Scans a sector byte stream for unpack headers and emits vertex and end-of-sector records.
// -----------------------------------------------------------------------------
//  channel | ports          | payload                          | dir
//  --------+----------------+----------------------------------+-----
//  req     | valid / stall  | byte_value                       | in
//  rsp     | valid / stall  | record kind, index, fields, last | out
//  csr     | wr_en          | index, wdata                     | in
//
//  One byte per cycle sustained while the result queue has room. A byte enters
//  the input register, then one pass of header decode and record assembly
//  writes up to two records into a four-entry result queue, whose registered
//  count drives rsp_valid. req_stall rises while a byte waits in the input
//  register and the queue has fewer than two free entries; rsp_stall only
//  holds the queue head. Synchronous reset; no clearing pass is needed.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module vif_unpack_vertex_extractor_unit #(
   parameter int OFFSET_BITS = vifx_pkg::OFFSET_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_byte_value,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_record_kind,
   output logic [15:0]                       rsp_record_index,
   output logic signed [15:0]                rsp_pos_x,
   output logic signed [15:0]                rsp_pos_y,
   output logic signed [15:0]                rsp_pos_z,
   output logic [15:0]                       rsp_vertex_flag,
   output logic signed [15:0]                rsp_tex_u,
   output logic signed [15:0]                rsp_tex_v,
   output logic [15:0]                       rsp_total_vertices,
   output logic                              rsp_last,

   input  logic                              csr_wr_en,
   input  logic [vifx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vifx_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [vifx_pkg::SIZE_W-1:0] sector_size_ff;
   logic [vifx_pkg::VTX_W-1:0]  max_vertices_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       go, room, accept;

   vifx_pkg::slots_type  slots, push;
   vifx_pkg::record_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_size_ff  <= vifx_pkg::SECTOR_SIZE_RST;
         max_vertices_ff <= vifx_pkg::MAX_VERTICES_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vifx_pkg::CSR_SECTOR_SIZE:  sector_size_ff  <= csr_wdata;
            vifx_pkg::CSR_MAX_VERTICES: max_vertices_ff <= csr_wdata[vifx_pkg::VTX_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: refill as the held item is processed
   assign go          = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (go ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_byte_value;
      end
   end

   vifx_parser #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .byte_value   (in_byte_ff),
      .sector_size  (sector_size_ff),
      .max_vertices (max_vertices_ff),
      .slots        (slots)
   );

   always_comb begin
      push = slots;
      if (!go) begin
         push.count = 2'd0;
      end
   end

   vifx_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_record_kind    = head.record_kind;
   assign rsp_record_index   = head.record_index;
   assign rsp_pos_x          = head.pos_x;
   assign rsp_pos_y          = head.pos_y;
   assign rsp_pos_z          = head.pos_z;
   assign rsp_vertex_flag    = head.vertex_flag;
   assign rsp_tex_u          = head.tex_u;
   assign rsp_tex_v          = head.tex_v;
   assign rsp_total_vertices = head.total_vertices;
   assign rsp_last           = head.last;

   `VIFX_ASSERT(a_last_is_end, rsp_valid |-> rsp_last == (rsp_record_kind == vifx_pkg::KIND_END), "last flag and end record disagree")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Streams sector bytes into the unpack vertex extractor under random
// configurations and handshake gaps. A tracker predicts every position, UV
// and end-of-sector record and checks the block's output field by field.
// -----------------------------------------------------------------------------

typedef enum logic [1:0] {SCAN_HDR, SCAN_SKIP, SCAN_POS, SCAN_UV} scan_mode_type;

class sector_tracker;
   logic [vifx_pkg::SIZE_W-1:0]          size_reg;
   logic [vifx_pkg::VTX_W-1:0]           vtx_cap;
   logic [vifx_pkg::OFFSET_BITS_DEF-1:0] offset;
   logic [23:0]                          window;
   logic [2:0]                           fill;
   scan_mode_type                        mode;
   logic [11:0]                          skip_left;
   logic [7:0]                           elem_left;
   logic [2:0]                           grab_pos;
   logic [63:0]                          grab_bits;
   logic [15:0]                          pos_count;
   logic [15:0]                          tex_count;
   vifx_pkg::record_type                 due_records[$];
   int                                   faults;
   int                                   byte_total;
   int                                   pos_seen;
   int                                   uv_seen;
   int                                   end_seen;

   function new();
      size_reg = vifx_pkg::SECTOR_SIZE_RST;
      vtx_cap = vifx_pkg::MAX_VERTICES_RST;
      faults = 0;
      byte_total = 0;
      pos_seen = 0;
      uv_seen = 0;
      end_seen = 0;
      restart_sector();
   endfunction

   // Payload length of an unpack command, rounded up to whole words.
   static function int unpack_bytes(logic [7:0] cmd, logic [7:0] num);
      int row;
      int elem;
      row = cmd[3:2] + 1;
      case (cmd[1:0])
         vifx_pkg::VL_16: elem = 2;
         vifx_pkg::VL_8: elem = 1;
         vifx_pkg::VL_5: begin
            row = 1;
            elem = 2;
         end
         default: elem = 4;
      endcase
      return (int'(num) * row * elem + 3) & ~3;
   endfunction

   function void back_to_scan();
      mode = SCAN_HDR;
      fill = '0;
      window = '0;
      grab_pos = '0;
      grab_bits = '0;
      elem_left = '0;
      skip_left = '0;
   endfunction

   function void restart_sector();
      back_to_scan();
      offset = '0;
      pos_count = '0;
      tex_count = '0;
   endfunction

   function void set_reg(logic [vifx_pkg::CSR_IDX_W-1:0] idx,
                         logic [vifx_pkg::CSR_DATA_W-1:0] val);
      if (idx == vifx_pkg::CSR_SECTOR_SIZE)
         size_reg = val[vifx_pkg::SIZE_W-1:0];
      else if (idx == vifx_pkg::CSR_MAX_VERTICES)
         vtx_cap = val[vifx_pkg::VTX_W-1:0];
   endfunction

   // Sector size clamped to 1 .. 2^OFFSET_BITS.
   function logic [vifx_pkg::OFFSET_BITS_DEF:0] span();
      logic [vifx_pkg::OFFSET_BITS_DEF:0] top;
      top = '0;
      top[vifx_pkg::OFFSET_BITS_DEF] = 1'b1;
      if (size_reg == '0)
         return (vifx_pkg::OFFSET_BITS_DEF + 1)'(1);
      if (size_reg > top)
         return top;
      return (vifx_pkg::OFFSET_BITS_DEF + 1)'(size_reg);
   endfunction

   function int pending();
      return due_records.size();
   endfunction

   function void take_byte(logic [7:0] b);
      logic [vifx_pkg::OFFSET_BITS_DEF:0] nxt;
      logic [7:0]  num;
      logic [63:0] bits;
      logic [2:0]  need;
      logic        live;
      int          bytes;
      vifx_pkg::record_type r;
      byte_total++;
      nxt = {1'b0, offset} + 1'b1;
      live = nxt < span();
      case (mode)
         SCAN_HDR: begin
            if (fill < 3) begin
               window = {window[15:0], b};
               fill++;
            end else begin
               num = window[7:0];
               if (live && b == vifx_pkg::CMD_STCYCL) begin
                  back_to_scan();
               end else if (live && (b & vifx_pkg::UNPACK_MASK) == vifx_pkg::UNPACK_MASK) begin
                  bytes = unpack_bytes(b, num);
                  back_to_scan();
                  if (b[3:2] == vifx_pkg::VN_V4 && b[1:0] == vifx_pkg::VL_16 && num != 0) begin
                     mode = SCAN_POS;
                     elem_left = num;
                  end else if (b[3:2] == vifx_pkg::VN_V2 && b[1:0] == vifx_pkg::VL_16
                               && num != 0) begin
                     mode = SCAN_UV;
                     elem_left = num;
                  end else if (bytes > 0) begin
                     mode = SCAN_SKIP;
                     skip_left = bytes[11:0];
                  end
               end else begin
                  window = {window[15:0], b};
               end
            end
         end
         SCAN_SKIP: begin
            if (skip_left != 0)
               skip_left--;
            if (skip_left == 0)
               back_to_scan();
         end
         default: begin
            need = (mode == SCAN_POS) ? 3'd7 : 3'd3;
            if (grab_pos < need) begin
               grab_bits |= 64'(b) << (8 * grab_pos);
               grab_pos++;
            end else begin
               bits = grab_bits | (64'(b) << (8 * need));
               r = '0;
               if (mode == SCAN_POS) begin
                  if (pos_count < vtx_cap) begin
                     r.record_kind = vifx_pkg::KIND_POS;
                     r.record_index = pos_count;
                     r.pos_x = bits[15:0];
                     r.pos_y = bits[31:16];
                     r.pos_z = bits[47:32];
                     r.vertex_flag = bits[63:48];
                     due_records.push_back(r);
                     pos_count++;
                  end
               end else if (tex_count < vtx_cap) begin
                  r.record_kind = vifx_pkg::KIND_UV;
                  r.record_index = tex_count;
                  r.tex_u = bits[15:0];
                  r.tex_v = bits[31:16];
                  due_records.push_back(r);
                  tex_count++;
               end
               grab_bits = '0;
               grab_pos = '0;
               if (elem_left != 0)
                  elem_left--;
               if (elem_left == 0)
                  back_to_scan();
            end
         end
      endcase
      if (!live) begin
         r = '0;
         r.record_kind = vifx_pkg::KIND_END;
         r.total_vertices = pos_count;
         r.last = 1'b1;
         due_records.push_back(r);
         restart_sector();
      end else begin
         offset++;
      end
   endfunction

   function void agree(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         faults++;
      end
   endfunction

   function void match_record(vifx_pkg::record_type got);
      vifx_pkg::record_type want;
      if (due_records.size() == 0) begin
         $error("record kind %0d index %0d arrived with none outstanding",
                got.record_kind, got.record_index);
         faults++;
         return;
      end
      want = due_records.pop_front();
      case (got.record_kind)
         vifx_pkg::KIND_POS: pos_seen++;
         vifx_pkg::KIND_UV: uv_seen++;
         default: end_seen++;
      endcase
      agree("record_kind", want.record_kind, got.record_kind);
      agree("record_index", want.record_index, got.record_index);
      agree("pos_x", want.pos_x, got.pos_x);
      agree("pos_y", want.pos_y, got.pos_y);
      agree("pos_z", want.pos_z, got.pos_z);
      agree("vertex_flag", want.vertex_flag, got.vertex_flag);
      agree("tex_u", want.tex_u, got.tex_u);
      agree("tex_v", want.tex_v, got.tex_v);
      agree("total_vertices", want.total_vertices, got.total_vertices);
      agree("last", want.last, got.last);
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_BYTES  = 850;
   localparam int SETTLE_CYCLES = 8;
   localparam int SETTLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES   = 80;
   localparam int PRESSURE_PHASE = 5;
   localparam logic [vifx_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;
   localparam logic [7:0] IRQ_BIT   = 8'h80;
   localparam logic [7:0] V4_16_CMD =
      vifx_pkg::UNPACK_MASK | {4'h0, vifx_pkg::VN_V4, vifx_pkg::VL_16};
   localparam logic [7:0] V2_16_CMD =
      vifx_pkg::UNPACK_MASK | {4'h0, vifx_pkg::VN_V2, vifx_pkg::VL_16};

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [7:0]                         req_byte_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_record_kind;
   logic [15:0]                        rsp_record_index;
   logic signed [15:0]                 rsp_pos_x;
   logic signed [15:0]                 rsp_pos_y;
   logic signed [15:0]                 rsp_pos_z;
   logic [15:0]                        rsp_vertex_flag;
   logic signed [15:0]                 rsp_tex_u;
   logic signed [15:0]                 rsp_tex_v;
   logic [15:0]                        rsp_total_vertices;
   logic                               rsp_last;
   logic                               csr_wr_en = 1'b0;
   logic [vifx_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [vifx_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   sector_tracker ledger;
   bit sender_calm = 1'b0;
   bit sink_calm = 1'b0;
   int sink_hold = 0;

   vif_unpack_vertex_extractor_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_record_index   (rsp_record_index),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_pos_z          (rsp_pos_z),
      .rsp_vertex_flag    (rsp_vertex_flag),
      .rsp_tex_u          (rsp_tex_u),
      .rsp_tex_v          (rsp_tex_v),
      .rsp_total_vertices (rsp_total_vertices),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin : rsp_monitor
      vifx_pkg::record_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.record_kind = rsp_record_kind;
         seen.record_index = rsp_record_index;
         seen.pos_x = rsp_pos_x;
         seen.pos_y = rsp_pos_y;
         seen.pos_z = rsp_pos_z;
         seen.vertex_flag = rsp_vertex_flag;
         seen.tex_u = rsp_tex_u;
         seen.tex_v = rsp_tex_v;
         seen.total_vertices = rsp_total_vertices;
         seen.last = rsp_last;
         ledger.match_record(seen);
      end
   end

   // Result side: per record, stall for a random gap, then take it.
   initial begin : rsp_sink
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = sink_calm ? 0 : $urandom_range(0, 6);
         if (sink_hold != 0) begin
            gap = sink_hold;
            sink_hold = 0;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $error("no completion within %0d cycles", CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      do @(posedge clock); while (req_stall);
      ledger.take_byte(b);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [vifx_pkg::CSR_IDX_W-1:0] idx,
                            input logic [vifx_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      ledger.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Drain all outstanding records, then let the pipeline empty.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (ledger.pending() != 0 && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] draw_count();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 8'd0;
      if (r == 9)
         return 8'($urandom_range(7, 255));
      return 8'($urandom_range(1, 6));
   endfunction

   // Append one command with its payload, or a little noise.
   task automatic add_chunk(ref logic [7:0] q[$]);
      int         pick;
      int         len;
      logic [7:0] num;
      logic [7:0] cmd;
      logic [1:0] vn;
      logic [1:0] vl;
      pick = $urandom_range(0, 99);
      num = draw_count();
      if (pick < 62) begin
         if (pick < 30) begin
            vn = vifx_pkg::VN_V4;
            vl = vifx_pkg::VL_16;
         end else if (pick < 50) begin
            vn = vifx_pkg::VN_V2;
            vl = vifx_pkg::VL_16;
         end else begin
            do begin
               vn = 2'($urandom);
               vl = 2'($urandom);
            end while (vl == vifx_pkg::VL_16 && (vn == vifx_pkg::VN_V4 || vn == vifx_pkg::VN_V2));
         end
         cmd = vifx_pkg::UNPACK_MASK | {1'($urandom), 2'b00, 1'($urandom), vn, vl};
         q.push_back(8'($urandom));
         q.push_back(8'($urandom));
         q.push_back(num);
         q.push_back(cmd);
         len = ledger.unpack_bytes(cmd, num);
         // break long payloads off early
         if (len > 48)
            len = $urandom_range(0, 48);
         repeat (len) q.push_back(8'($urandom));
      end else if (pick < 75) begin
         repeat (3) q.push_back(8'($urandom));
         q.push_back(vifx_pkg::CMD_STCYCL);
      end else begin
         repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
      end
   endtask

   task automatic send_sector(input int len);
      logic [7:0] bytes_q[$];
      while (bytes_q.size() < len)
         add_chunk(bytes_q);
      for (int i = 0; i < len; i++)
         push_byte(bytes_q[i]);
   endtask

   initial begin : stimulus
      logic [7:0] opening [24] = '{
         8'h00, 8'hFF, 8'h01, V4_16_CMD,
         8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00,
         8'hFF, 8'hFF, 8'h02, IRQ_BIT | V2_16_CMD,
         8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'h00, 8'h10};
      logic [vifx_pkg::CSR_DATA_W-1:0] size_val;
      logic [vifx_pkg::CSR_DATA_W-1:0] cap_val;
      int size_int;
      int cap_int;
      int phase;
      int start;
      int mark;
      ledger = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero size acts as one byte per sector
      write_csr(vifx_pkg::CSR_SECTOR_SIZE, '0);
      write_csr(vifx_pkg::CSR_MAX_VERTICES,
                vifx_pkg::CSR_DATA_W'(vifx_pkg::MAX_VERTICES_RST));
      push_byte(8'hFF);
      settle();
      // one position and two UVs with a cap of one: second UV is dropped
      write_csr(vifx_pkg::CSR_SECTOR_SIZE, vifx_pkg::CSR_DATA_W'(24));
      write_csr(vifx_pkg::CSR_MAX_VERTICES, vifx_pkg::CSR_DATA_W'(1));
      foreach (opening[i])
         push_byte(opening[i]);

      phase = 0;
      start = ledger.byte_total;
      while (ledger.byte_total - start < RANDOM_BYTES) begin
         settle();
         case (phase)
            0: begin size_int = 64; cap_int = int'(vifx_pkg::MAX_VERTICES_RST); end
            1: begin
               size_int = (1 << vifx_pkg::CSR_DATA_W) - 1;
               cap_int = $urandom_range(4, 65534);
            end
            2: begin size_int = 16; cap_int = 3; end
            3: begin size_int = 5; cap_int = int'(vifx_pkg::MAX_VERTICES_RST); end
            4: begin size_int = 200; cap_int = 0; end
            5: begin size_int = 120; cap_int = int'(vifx_pkg::MAX_VERTICES_RST); end
            6: begin size_int = 1 << vifx_pkg::OFFSET_BITS_DEF; cap_int = 2; end
            7: begin size_int = (1 << vifx_pkg::OFFSET_BITS_DEF) + 1; cap_int = 1; end
            8: begin size_int = 3; cap_int = int'(vifx_pkg::MAX_VERTICES_RST); end
            default: begin
               size_int = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 8)
                                                       : $urandom_range(9, 160);
               cap_int = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(4, 65535);
            end
         endcase
         size_val = vifx_pkg::CSR_DATA_W'(size_int);
         cap_val = vifx_pkg::CSR_DATA_W'(cap_int);
         write_csr(vifx_pkg::CSR_SECTOR_SIZE, size_val);
         write_csr(vifx_pkg::CSR_MAX_VERTICES, cap_val);
         if (phase == 8)
            write_csr(CSR_SPARE_IDX, vifx_pkg::CSR_DATA_W'($urandom));
         sender_calm = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         if (phase == PRESSURE_PHASE) begin
            sender_calm = 1'b1;
            sink_hold = HOLD_CYCLES;
         end
         // huge sectors are streamed only in part; a later, smaller size ends them
         if (size_val > 256) begin
            send_sector($urandom_range(40, 80));
         end else begin
            mark = ledger.byte_total;
            while (ledger.byte_total - mark < 80)
               send_sector(size_val);
         end
         phase++;
      end

      settle();
      if (ledger.pending() != 0) begin
         $error("%0d records never arrived", ledger.pending());
         ledger.faults++;
      end
      $display("Streamed %0d bytes over %0d random configurations.",
               ledger.byte_total, phase);
      $display("Checked %0d position, %0d UV and %0d end-of-sector records.",
               ledger.pos_seen, ledger.uv_seen, ledger.end_seen);
      if (ledger.faults == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/vifx_pkg.sv
sv/vifx_parser.sv
sv/vifx_rsp_fifo.sv
sv/vif_unpack_vertex_extractor_unit.sv
dv/testbench.sv
